// ===== design/tws_pkg.sv =====
// Shared types and constants for the three-wire serial master.
// Used by tws_step and three_wire_serial_master_top; no dependencies.
package tws_pkg;

    // Phase counter width and step indexes of a transaction.
    localparam int PHASE_W    = 6;
    localparam int ADDR_LAST  = 18;  // last step of the address byte
    localparam int WRITE_LAST = 35;  // final step of a write
    localparam int READ_LAST  = 39;  // final step of a read
    localparam int TAIL_CE    = 35;  // read tail: enable low, driver back on
    localparam int TAIL_SCK_L = 36;  // read tail: clock low
    localparam int TAIL_SCK_H = 37;  // read tail: clock high
    localparam int TAIL_DAT_L = 38;  // read tail: data low

    // Steps opening the transaction.
    localparam int STEP_CE_LOW  = 0;
    localparam int STEP_SCK_LOW = 1;
    localparam int STEP_CE_HIGH = 2;

    localparam int BYTE_W = 8;
    localparam int SEND_W = 16;

    // Input command codes (tuser).
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Sequencer state and pin levels.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               is_read;
        logic [SEND_W-1:0]  send_shift;
        logic [BYTE_W-1:0]  capture_shift;
        logic [BYTE_W-1:0]  last_read_byte;
        logic               sck;
        logic               ce;
        logic               data;
        logic               drive;
    } tws_state_t;

endpackage

// ===== design/tws_step.sv =====
// One tick of the three-wire transaction sequencer, purely combinational.
// Depends on tws_pkg for the state type, step indexes and command codes.
module tws_step (
    input  tws_pkg::tws_state_t st,
    input  logic [1:0]          op,
    input  logic [7:0]          address,
    input  logic [7:0]          write_data,
    input  logic                sda_in,
    output tws_pkg::tws_state_t st_next,
    output logic                done
);
    import tws_pkg::*;

    // Work out the step index for this tick and apply it.
    always_comb
    begin
        tws_state_t           s;
        logic                 active;
        logic [PHASE_W-1:0]   k;
        logic [PHASE_W-1:0]   last;

        s      = st;
        active = 1'b0;
        done   = 1'b0;
        k      = '0;

        if (st.phase == '0)
        begin
            // An idle tick may start a transaction; the start tick runs step 0.
            case (op_t'(op))
                OP_WRITE:
                begin
                    s.is_read       = 1'b0;
                    s.send_shift    = {write_data, address};
                    s.capture_shift = '0;
                    active          = 1'b1;
                end
                OP_READ:
                begin
                    s.is_read       = 1'b1;
                    s.send_shift    = {8'd0, address};
                    s.capture_shift = '0;
                    active          = 1'b1;
                end
                default:
                begin
                    active = 1'b0;
                end
            endcase
        end
        else
        begin
            k      = st.phase;
            active = 1'b1;
        end

        last = s.is_read ? PHASE_W'(READ_LAST) : PHASE_W'(WRITE_LAST);
        if (k > last)
        begin
            k = last;
        end

        if (active)
        begin
            if (k == PHASE_W'(STEP_CE_LOW))
            begin
                s.ce = 1'b0;
            end
            else if (k == PHASE_W'(STEP_SCK_LOW))
            begin
                s.sck = 1'b0;
            end
            else if (k == PHASE_W'(STEP_CE_HIGH))
            begin
                s.ce = 1'b1;
            end
            else if (k <= PHASE_W'(ADDR_LAST) ||
                     (!s.is_read && k < PHASE_W'(WRITE_LAST)))
            begin
                // Send bits: odd step sets data with clock low, even step raises clock.
                if (k[0])
                begin
                    s.sck        = 1'b0;
                    s.data       = s.send_shift[0];
                    s.send_shift = s.send_shift >> 1;
                end
                else
                begin
                    s.sck = 1'b1;
                end
            end
            else if (!s.is_read)
            begin
                // Write ends with enable low.
                s.ce = 1'b0;
                done = 1'b1;
            end
            else if (k < PHASE_W'(TAIL_CE))
            begin
                // Read bits: line released, sample on the clock-low step, MSB side in.
                s.drive = 1'b0;
                if (k[0])
                begin
                    s.sck           = 1'b0;
                    s.capture_shift = {sda_in, s.capture_shift[BYTE_W-1:1]};
                end
                else
                begin
                    s.sck = 1'b1;
                end
            end
            else if (k == PHASE_W'(TAIL_CE))
            begin
                s.ce    = 1'b0;
                s.drive = 1'b1;
            end
            else if (k == PHASE_W'(TAIL_SCK_L))
            begin
                s.sck = 1'b0;
            end
            else if (k == PHASE_W'(TAIL_SCK_H))
            begin
                s.sck = 1'b1;
            end
            else if (k == PHASE_W'(TAIL_DAT_L))
            begin
                s.data = 1'b0;
            end
            else
            begin
                s.data           = 1'b1;
                s.last_read_byte = s.capture_shift;
                done             = 1'b1;
            end

            s.phase = done ? '0 : k + PHASE_W'(1);
        end

        st_next = s;
    end

endmodule

// ===== design/three_wire_serial_master_top.sv =====
// Top level of the three-wire serial master: stream ports, state and result registers.
// Depends on tws_pkg and instantiates tws_step.
//
// Each accepted input word is one pin-timing tick and yields exactly one result
// word; one word per clock cycle is sustained while m_tready stays high. The
// sequencer state is updated on the accepting edge and the result lands in a single
// output register, so input is taken whenever that register is empty or being
// drained in the same cycle. A write takes 36 ticks and a read 40 ticks.
module three_wire_serial_master_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] address, [15:8] write_data, [16] sda_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] sck, [1] chip_enable, [2] sda_out,
                                   // [3] sda_drive, [11:4] read_data,
                                   // [12] done_res, [13] busy_res
);
    import tws_pkg::*;

    tws_state_t  st_reg;
    tws_state_t  st_next;
    logic        step_done;
    logic        m_tvalid_reg;
    logic [15:0] out_reg;
    logic [15:0] out_next;
    logic        in_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    tws_step u_step (
        .st         (st_reg),
        .op         (s_tuser),
        .address    (s_tdata[7:0]),
        .write_data (s_tdata[15:8]),
        .sda_in     (s_tdata[16]),
        .st_next    (st_next),
        .done       (step_done)
    );

    // Result word packed from the state after this tick.
    assign out_next = {2'b00,
                       (st_next.phase != '0),
                       step_done,
                       st_next.last_read_byte,
                       st_next.drive,
                       st_next.data,
                       st_next.ce,
                       st_next.sck};

    // Sequencer state; pins start with clock and enable low, data high and driven.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: '0, is_read: 1'b0, send_shift: '0, capture_shift: '0,
                        last_read_byte: '0, sck: 1'b0, ce: 1'b0, data: 1'b1,
                        drive: 1'b1};
        end
        else if (in_accept)
        begin
            st_reg <= st_next;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // The phase never runs past the final step of the current transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase <= (st_reg.is_read ? PHASE_W'(READ_LAST) : PHASE_W'(WRITE_LAST)))
        else $error("phase beyond final step");

    // The data line is only released during a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.drive |-> st_reg.is_read && st_reg.phase != '0)
        else $error("data line released outside a read");

    // A finishing tick returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && step_done |=> st_reg.phase == '0)
        else $error("sequencer not idle after final tick");

    // A result word never claims done and busy together.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && out_reg[12] |-> !out_reg[13])
        else $error("done and busy both set");
`endif

endmodule
